/* src/ocpp_pkg.sv */
// Shared types and constants of the orbit camera projection core.
// No dependencies; used by orbit_camera_perspective_project_core.
package ocpp_pkg;

   localparam int COORD_W     = 16;
   localparam int ANGLE_W     = 8;
   localparam int ANGLE_STEPS = 256;
   localparam int TRIG_W      = 16;
   localparam int OUT_W       = 16;
   localparam int FOCAL_W     = 10;
   localparam int DIST_W      = 15;
   localparam int CENTER_W    = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   localparam int TILT_COS   = 12;
   localparam int TILT_SIN   = 5;
   localparam int TILT_HYP   = 13;
   localparam int UNIT_SHIFT = 15;

   localparam logic [FOCAL_W-1:0]  FOCAL_RESET    = FOCAL_W'(320);
   localparam logic [DIST_W-1:0]   DISTANCE_RESET = DIST_W'(3328);
   localparam logic [DIST_W-1:0]   NEAR_RESET     = DIST_W'(256);
   localparam logic [CENTER_W-1:0] CENTER_X_RESET = CENTER_W'(256);
   localparam logic [CENTER_W-1:0] CENTER_Y_RESET = CENTER_W'(240);

   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
   localparam longint COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOCAL_LENGTH    = 3'd0,
      CSR_CAMERA_DISTANCE = 3'd1,
      CSR_NEAR_LIMIT      = 3'd2,
      CSR_CENTER_X        = 3'd3,
      CSR_CENTER_Y        = 3'd4
   } csr_index_type;

   typedef logic signed [TRIG_W-1:0] trig_table_type [ANGLE_STEPS];

endpackage

/* src/orbit_camera_perspective_project_core.sv */
// Orbit camera perspective projection core: rotation, tilt, depth and divide pipeline.
// Depends on ocpp_pkg for widths, register codes, series divisors and table type.
//
// Usage:
//   req_* carries one vertex (Q8.8 x, y, z) and a yaw index per transfer; rsp_* returns
//   screen_x, screen_y and visible for it, in input order. csr_* writes the five setup
//   registers (focal length, camera distance, near limit, screen centre x and y); write
//   them only while no vertex is in flight. csr_ready is always high.
//   Throughput: one vertex per cycle while the receiver keeps up. The pipe has 26 stages,
//   17 of which form the restoring divider that yields one quotient bit per stage for
//   both screen axes at once.
//   Sine and cosine come from two 256-entry constant tables built at elaboration from a
//   Taylor series over SINE_ENTRIES steps per turn.
//   Reset clears all stage valid bits and loads the register defaults.
//   When rsp_ready is low the last stage holds; earlier stages keep advancing into empty
//   slots, so req_ready drops only when every stage holds a vertex.
module orbit_camera_perspective_project_core #(
   parameter int SINE_ENTRIES = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [ocpp_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [ocpp_pkg::COORD_W-1:0]     req_point_y,
   input  logic signed [ocpp_pkg::COORD_W-1:0]     req_point_z,
   input  logic        [ocpp_pkg::ANGLE_W-1:0]     req_angle_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ocpp_pkg::OUT_W-1:0]       rsp_screen_x,
   output logic signed [ocpp_pkg::OUT_W-1:0]       rsp_screen_y,
   output logic                                    rsp_visible,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [ocpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [ocpp_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int W_PROD   = ocpp_pkg::COORD_W + ocpp_pkg::TRIG_W;
   localparam int W_SUM    = W_PROD + 1;
   localparam int W_CAM    = W_SUM + 5;
   localparam int W_DEP    = W_CAM - 1;
   localparam int W_MUL    = W_CAM + ocpp_pkg::FOCAL_W;
   localparam int W_NUM    = W_MUL + 1;
   localparam int W_MAG    = W_NUM - 1;
   localparam int DIV_BITS = ocpp_pkg::OUT_W + 1;
   localparam int W_REM    = W_DEP + DIV_BITS;

   localparam int ST_IN   = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_ROT  = 2;
   localparam int ST_CAM  = 3;
   localparam int ST_SCL  = 4;
   localparam int ST_NUM  = 5;
   localparam int ST_MAG  = 6;
   localparam int ST_OVF  = 7;
   localparam int ST_DIV0 = ST_OVF + 1;
   localparam int ST_OUT  = ST_OVF + DIV_BITS + 1;
   localparam int NUM_ST  = ST_OUT + 1;

   localparam int POS_MAX = 2 ** (ocpp_pkg::OUT_W - 1) - 1;

   function automatic longint series(input longint x2, input logic use_cos);
      longint t;
      t = ocpp_pkg::ONE_Q30;
      for (int i = 0; i < 6; i++) begin
         if (use_cos) begin
            t = ocpp_pkg::ONE_Q30 - ((x2 * t) >>> 30) / ocpp_pkg::COS_DIV[i];
         end else begin
            t = ocpp_pkg::ONE_Q30 - ((x2 * t) >>> 30) / ocpp_pkg::SIN_DIV[i];
         end
         if (t < 0) begin
            t = 0;
         end
      end
      return t;
   endfunction

   function automatic logic signed [ocpp_pkg::TRIG_W-1:0] rom_entry(input longint k);
      longint k4;
      longint quad;
      longint theta;
      longint x2;
      longint v;
      longint m;
      k4    = (k % SINE_ENTRIES) * 4;
      quad  = (k4 / SINE_ENTRIES) & 3;
      theta = (k4 % SINE_ENTRIES) * ocpp_pkg::HALF_PI_Q30 / SINE_ENTRIES;
      x2    = (theta * theta) >>> 30;
      if (quad[0]) begin
         v = series(x2, 1'b1);
      end else begin
         v = (theta * series(x2, 1'b0)) >>> 30;
      end
      m = (v + 16384) >>> 15;
      if (m > 32767) begin
         m = 32767;
      end
      return quad[1] ? ocpp_pkg::TRIG_W'(-m) : ocpp_pkg::TRIG_W'(m);
   endfunction

   function automatic ocpp_pkg::trig_table_type build_table(input logic use_cos);
      ocpp_pkg::trig_table_type tab;
      longint idx;
      for (int a = 0; a < ocpp_pkg::ANGLE_STEPS; a++) begin
         idx = (longint'(a) * SINE_ENTRIES / ocpp_pkg::ANGLE_STEPS) % SINE_ENTRIES;
         if (use_cos) begin
            idx = (idx + SINE_ENTRIES / 4) % SINE_ENTRIES;
         end
         tab[a] = rom_entry(idx);
      end
      return tab;
   endfunction

   function automatic logic signed [ocpp_pkg::OUT_W-1:0] saturate(
      input logic neg, input logic ovf, input logic [DIV_BITS-1:0] q);
      logic signed [ocpp_pkg::OUT_W-1:0] r;
      priority if (ovf) begin
         r = neg ? ocpp_pkg::OUT_W'(POS_MAX + 1) : ocpp_pkg::OUT_W'(POS_MAX);
      end else if (!neg && q > DIV_BITS'(POS_MAX)) begin
         r = ocpp_pkg::OUT_W'(POS_MAX);
      end else if (neg && q > DIV_BITS'(POS_MAX + 1)) begin
         r = ocpp_pkg::OUT_W'(POS_MAX + 1);
      end else begin
         r = neg ? -ocpp_pkg::OUT_W'(q) : ocpp_pkg::OUT_W'(q);
      end
      return r;
   endfunction

   localparam ocpp_pkg::trig_table_type SIN_TABLE = build_table(1'b0);
   localparam ocpp_pkg::trig_table_type COS_TABLE = build_table(1'b1);

   // setup registers
   logic [ocpp_pkg::FOCAL_W-1:0]  focal_ff,    focal_in;
   logic [ocpp_pkg::DIST_W-1:0]   distance_ff, distance_in;
   logic [ocpp_pkg::DIST_W-1:0]   near_ff,     near_in;
   logic [ocpp_pkg::CENTER_W-1:0] cx_ff,       cx_in;
   logic [ocpp_pkg::CENTER_W-1:0] cy_ff,       cy_in;

   // stage control
   logic [NUM_ST-1:0] stage_valid_ff, stage_valid_in;
   logic [NUM_ST-1:0] stage_en;

   // stage payloads
   logic signed [ocpp_pkg::COORD_W-1:0] st0_px_ff, st0_py_ff, st0_pz_ff;
   logic signed [ocpp_pkg::TRIG_W-1:0]  st0_sin_ff, st0_sin_in, st0_cos_ff, st0_cos_in;
   logic signed [W_PROD-1:0]            st1_xc_ff, st1_zs_ff, st1_xs_ff, st1_zc_ff;
   logic signed [W_PROD-1:0]            st1_xc_in, st1_zs_in, st1_xs_in, st1_zc_in;
   logic signed [ocpp_pkg::COORD_W-1:0] st1_py_ff, st2_py_ff;
   logic signed [W_SUM-1:0]             st2_a_ff, st2_a_in, st2_b_ff, st2_b_in;
   logic signed [W_CAM-1:0]             py_unit, dist_unit, near_unit, near_bound;
   logic signed [W_CAM-1:0]             st3_x13_ff, st3_x13_in, st3_y13_ff, st3_y13_in;
   logic signed [W_CAM-1:0]             st3_dep_ff, st3_dep_in;
   logic signed [W_MUL-1:0]             st4_fx_ff, st4_fx_in, st4_fy_ff, st4_fy_in;
   logic        [W_MUL-1:0]             st4_cxd_ff, st4_cxd_in, st4_cyd_ff, st4_cyd_in;
   logic        [W_DEP-1:0]             st4_dep_ff, st5_dep_ff, st6_dep_ff;
   logic                                st4_vis_ff, st4_vis_in, st5_vis_ff, st6_vis_ff;
   logic signed [W_NUM-1:0]             st5_nx_ff, st5_nx_in, st5_ny_ff, st5_ny_in;
   logic        [W_MAG-1:0]             st6_magx_ff, st6_magx_in, st6_magy_ff, st6_magy_in;
   logic                                st6_negx_ff, st6_negy_ff;

   // divider stages, entry j holds the state after j quotient bits
   logic [W_REM-1:0]    rx_ff [DIV_BITS+1];
   logic [W_REM-1:0]    rx_in [DIV_BITS+1];
   logic [W_REM-1:0]    ry_ff [DIV_BITS+1];
   logic [W_REM-1:0]    ry_in [DIV_BITS+1];
   logic [DIV_BITS-1:0] qx_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] qx_in [DIV_BITS+1];
   logic [DIV_BITS-1:0] qy_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] qy_in [DIV_BITS+1];
   logic [W_DEP-1:0]    dd_ff [DIV_BITS+1];
   logic [W_DEP-1:0]    dd_in [DIV_BITS+1];
   logic [DIV_BITS:0]   negx_ff, negx_in, negy_ff, negy_in;
   logic [DIV_BITS:0]   ovfx_ff, ovfx_in, ovfy_ff, ovfy_in;
   logic [DIV_BITS:0]   dvis_ff, dvis_in;
   logic [W_REM:0]      trial_x, trial_y;

   logic signed [ocpp_pkg::OUT_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                              out_vis_ff;

   // configuration port
   assign csr_ready = 1'b1;

   always_comb begin
      focal_in    = focal_ff;
      distance_in = distance_ff;
      near_in     = near_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ocpp_pkg::CSR_FOCAL_LENGTH:    focal_in    = csr_data[ocpp_pkg::FOCAL_W-1:0];
            ocpp_pkg::CSR_CAMERA_DISTANCE: distance_in = csr_data[ocpp_pkg::DIST_W-1:0];
            ocpp_pkg::CSR_NEAR_LIMIT:      near_in     = csr_data[ocpp_pkg::DIST_W-1:0];
            ocpp_pkg::CSR_CENTER_X:        cx_in       = csr_data[ocpp_pkg::CENTER_W-1:0];
            ocpp_pkg::CSR_CENTER_Y:        cy_in       = csr_data[ocpp_pkg::CENTER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= ocpp_pkg::FOCAL_RESET;
         distance_ff <= ocpp_pkg::DISTANCE_RESET;
         near_ff     <= ocpp_pkg::NEAR_RESET;
         cx_ff       <= ocpp_pkg::CENTER_X_RESET;
         cy_ff       <= ocpp_pkg::CENTER_Y_RESET;
      end else begin
         focal_ff    <= focal_in;
         distance_ff <= distance_in;
         near_ff     <= near_in;
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
      end
   end

   // stage advance: a stage loads when it is empty or its successor loads
   always_comb begin
      stage_en[ST_OUT] = !stage_valid_ff[ST_OUT] || rsp_ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
      stage_valid_in[ST_IN] = stage_en[ST_IN] ? req_valid : stage_valid_ff[ST_IN];
      for (int k = 1; k < NUM_ST; k++) begin
         stage_valid_in[k] = stage_en[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_ready = stage_en[ST_IN];

   // input: latch vertex, look up yaw sine and cosine
   assign st0_sin_in = SIN_TABLE[req_angle_index];
   assign st0_cos_in = COS_TABLE[req_angle_index];

   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         st0_px_ff  <= req_point_x;
         st0_py_ff  <= req_point_y;
         st0_pz_ff  <= req_point_z;
         st0_sin_ff <= st0_sin_in;
         st0_cos_ff <= st0_cos_in;
      end
   end

   // yaw products
   assign st1_xc_in = W_PROD'(st0_px_ff) * W_PROD'(st0_cos_ff);
   assign st1_zs_in = W_PROD'(st0_pz_ff) * W_PROD'(st0_sin_ff);
   assign st1_xs_in = W_PROD'(st0_px_ff) * W_PROD'(st0_sin_ff);
   assign st1_zc_in = W_PROD'(st0_pz_ff) * W_PROD'(st0_cos_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL]) begin
         st1_xc_ff <= st1_xc_in;
         st1_zs_ff <= st1_zs_in;
         st1_xs_ff <= st1_xs_in;
         st1_zc_ff <= st1_zc_in;
         st1_py_ff <= st0_py_ff;
      end
   end

   // rotated x and z
   assign st2_a_in = W_SUM'(st1_xc_ff) - W_SUM'(st1_zs_ff);
   assign st2_b_in = W_SUM'(st1_xs_ff) + W_SUM'(st1_zc_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_ROT]) begin
         st2_a_ff  <= st2_a_in;
         st2_b_ff  <= st2_b_in;
         st2_py_ff <= st1_py_ff;
      end
   end

   // tilt and camera offset, all scaled by 13 * 2^23
   assign py_unit   = W_CAM'(st2_py_ff) <<< ocpp_pkg::UNIT_SHIFT;
   assign dist_unit = $signed(W_CAM'(distance_ff)) <<< ocpp_pkg::UNIT_SHIFT;
   assign st3_x13_in = W_CAM'(st2_a_ff) * W_CAM'(ocpp_pkg::TILT_HYP);
   assign st3_y13_in = W_CAM'(ocpp_pkg::TILT_COS) * py_unit
                     - W_CAM'(ocpp_pkg::TILT_SIN) * W_CAM'(st2_b_ff);
   assign st3_dep_in = W_CAM'(ocpp_pkg::TILT_HYP) * dist_unit
                     - W_CAM'(ocpp_pkg::TILT_COS) * W_CAM'(st2_b_ff)
                     - W_CAM'(ocpp_pkg::TILT_SIN) * py_unit;

   always_ff @(posedge clock) begin
      if (stage_en[ST_CAM]) begin
         st3_x13_ff <= st3_x13_in;
         st3_y13_ff <= st3_y13_in;
         st3_dep_ff <= st3_dep_in;
      end
   end

   // near test and perspective products
   assign near_unit  = $signed(W_CAM'(near_ff)) <<< ocpp_pkg::UNIT_SHIFT;
   assign near_bound = W_CAM'(ocpp_pkg::TILT_HYP) * near_unit;
   assign st4_vis_in = (st3_dep_ff > 0) && (st3_dep_ff >= near_bound);
   assign st4_fx_in  = W_MUL'($signed({1'b0, focal_ff})) * W_MUL'(st3_x13_ff);
   assign st4_fy_in  = W_MUL'($signed({1'b0, focal_ff})) * W_MUL'(st3_y13_ff);
   assign st4_cxd_in = W_MUL'(cx_ff) * W_MUL'(st3_dep_ff[W_DEP-1:0]);
   assign st4_cyd_in = W_MUL'(cy_ff) * W_MUL'(st3_dep_ff[W_DEP-1:0]);

   always_ff @(posedge clock) begin
      if (stage_en[ST_SCL]) begin
         st4_vis_ff <= st4_vis_in;
         st4_dep_ff <= st3_dep_ff[W_DEP-1:0];
         st4_fx_ff  <= st4_fx_in;
         st4_fy_ff  <= st4_fy_in;
         st4_cxd_ff <= st4_cxd_in;
         st4_cyd_ff <= st4_cyd_in;
      end
   end

   // numerators: centre * depth +- f * coordinate
   assign st5_nx_in = $signed(W_NUM'(st4_cxd_ff)) + W_NUM'(st4_fx_ff);
   assign st5_ny_in = $signed(W_NUM'(st4_cyd_ff)) - W_NUM'(st4_fy_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_NUM]) begin
         st5_nx_ff  <= st5_nx_in;
         st5_ny_ff  <= st5_ny_in;
         st5_dep_ff <= st4_dep_ff;
         st5_vis_ff <= st4_vis_ff;
      end
   end

   // sign and magnitude
   assign st6_magx_in = st5_nx_ff[W_NUM-1] ? W_MAG'(-st5_nx_ff) : W_MAG'(st5_nx_ff);
   assign st6_magy_in = st5_ny_ff[W_NUM-1] ? W_MAG'(-st5_ny_ff) : W_MAG'(st5_ny_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         st6_magx_ff <= st6_magx_in;
         st6_magy_ff <= st6_magy_in;
         st6_negx_ff <= st5_nx_ff[W_NUM-1];
         st6_negy_ff <= st5_ny_ff[W_NUM-1];
         st6_dep_ff  <= st5_dep_ff;
         st6_vis_ff  <= st5_vis_ff;
      end
   end

   // overflow check, then one restoring quotient bit per stage
   always_comb begin
      rx_in[0]   = W_REM'(st6_magx_ff);
      ry_in[0]   = W_REM'(st6_magy_ff);
      qx_in[0]   = '0;
      qy_in[0]   = '0;
      dd_in[0]   = st6_dep_ff;
      negx_in[0] = st6_negx_ff;
      negy_in[0] = st6_negy_ff;
      dvis_in[0] = st6_vis_ff;
      ovfx_in[0] = W_REM'(st6_magx_ff) >= (W_REM'(st6_dep_ff) << DIV_BITS);
      ovfy_in[0] = W_REM'(st6_magy_ff) >= (W_REM'(st6_dep_ff) << DIV_BITS);
      trial_x    = '0;
      trial_y    = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial_x = {1'b0, rx_ff[j]} - {1'b0, W_REM'(dd_ff[j]) << (DIV_BITS - 1 - j)};
         trial_y = {1'b0, ry_ff[j]} - {1'b0, W_REM'(dd_ff[j]) << (DIV_BITS - 1 - j)};
         rx_in[j+1] = trial_x[W_REM] ? rx_ff[j] : trial_x[W_REM-1:0];
         ry_in[j+1] = trial_y[W_REM] ? ry_ff[j] : trial_y[W_REM-1:0];
         qx_in[j+1] = qx_ff[j];
         qy_in[j+1] = qy_ff[j];
         qx_in[j+1][DIV_BITS-1-j] = !trial_x[W_REM];
         qy_in[j+1][DIV_BITS-1-j] = !trial_y[W_REM];
         dd_in[j+1]   = dd_ff[j];
         negx_in[j+1] = negx_ff[j];
         negy_in[j+1] = negy_ff[j];
         ovfx_in[j+1] = ovfx_ff[j];
         ovfy_in[j+1] = ovfy_ff[j];
         dvis_in[j+1] = dvis_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= DIV_BITS; j++) begin
         if (stage_en[ST_OVF+j]) begin
            rx_ff[j]   <= rx_in[j];
            ry_ff[j]   <= ry_in[j];
            qx_ff[j]   <= qx_in[j];
            qy_ff[j]   <= qy_in[j];
            dd_ff[j]   <= dd_in[j];
            negx_ff[j] <= negx_in[j];
            negy_ff[j] <= negy_in[j];
            ovfx_ff[j] <= ovfx_in[j];
            ovfy_ff[j] <= ovfy_in[j];
            dvis_ff[j] <= dvis_in[j];
         end
      end
   end

   // apply sign, saturate, zero hidden vertices
   assign out_x_in = dvis_ff[DIV_BITS]
                   ? saturate(negx_ff[DIV_BITS], ovfx_ff[DIV_BITS], qx_ff[DIV_BITS]) : '0;
   assign out_y_in = dvis_ff[DIV_BITS]
                   ? saturate(negy_ff[DIV_BITS], ovfy_ff[DIV_BITS], qy_ff[DIV_BITS]) : '0;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_vis_ff <= dvis_ff[DIV_BITS];
      end
   end

   assign rsp_valid    = stage_valid_ff[ST_OUT];
   assign rsp_screen_x = out_x_ff;
   assign rsp_screen_y = out_y_ff;
   assign rsp_visible  = out_vis_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("hidden vertex carries nonzero screen coordinates");

   a_visible_depth: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[ST_SCL] && st4_vis_ff |-> st4_dep_ff != '0)
      else $error("visible vertex with zero depth");

   a_final_remainder: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[ST_OUT-1] && dvis_ff[DIV_BITS] && !ovfx_ff[DIV_BITS]
      |-> rx_ff[DIV_BITS] < W_REM'(dd_ff[DIV_BITS]))
      else $error("divider remainder not below divisor");

   a_divider_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[ST_DIV0] && !stage_en[ST_DIV0]
      |=> $stable(rx_ff[1]) && $stable(ry_ff[1]) && $stable(qx_ff[1]))
      else $error("stalled divider stage changed");

   a_output_load: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[ST_OUT-1] && stage_en[ST_OUT] |=> rsp_valid)
      else $error("vertex lost on entry to output stage");

endmodule
